@@ rtl/core/svl_pkg.sv @@
// Shared types and constants for the sorted value list.
package svl_pkg;

  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 16;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // Action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                      valid;
    logic                      lt;     // holds an entry smaller than the operand
    logic                      eq;     // holds an entry equal to the operand
    logic signed [VALUE_W-1:0] value;
  } svl_link_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic                      ins_go;
    logic                      del_go;
    logic signed [VALUE_W-1:0] operand;
  } svl_op_t;

endpackage

@@ rtl/core/sorted_value_list.sv @@
// Sorted value list: a row of compare-and-shift cells with a registered result beat.
// The registered result beat appears in the cycle after the input beat is accepted.
// Throughput: one item per cycle unless stalled; each cell compares and shifts one place.
// The input stalls only while a finished result beat waits on a stalled output.
// Reset (rst_n low, synchronous) empties the list and drops any pending result beat;
// stored values are not cleared, only their valid bits.
module sorted_value_list
  import svl_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_action,
  input  logic signed [VALUE_W-1:0] in_operand,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STATUS_W-1:0]       out_status,
  output logic signed [VALUE_W-1:0] out_result_value,
  output logic [CNT_W-1:0]          out_entry_count,
  output logic signed [VALUE_W-1:0] out_smallest
);

  svl_link_t                 links [CAPACITY+2];
  logic [CAPACITY-1:0]       vld_vec;
  logic [CAPACITY-1:0]       eq_vec;
  logic [CAPACITY-1:0]       cell_valid_nxt;
  logic signed [VALUE_W-1:0] cell_value_nxt [CAPACITY];
  svl_op_t                   op;

  logic                      accept;
  logic                      full;
  logic                      found;
  logic [CNT_W-1:0]          fill_r, fill_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]       status_r, status_nxt;
  logic signed [VALUE_W-1:0] result_r, result_nxt;
  logic [CNT_W-1:0]          count_r;
  logic signed [VALUE_W-1:0] smallest_r, smallest_nxt;

  // Row boundaries: the left edge looks smaller than anything, the right edge is empty
  assign links[0]          = '{valid: 1'b1, lt: 1'b1, eq: 1'b0, value: '0};
  assign links[CAPACITY+1] = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, value: '0};

  // Build the cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    svl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .op        (op),
      .left_in   (links[i]),
      .right_in  (links[i+2]),
      .link_out  (links[i+1]),
      .valid_nxt (cell_valid_nxt[i]),
      .value_nxt (cell_value_nxt[i])
    );
    assign vld_vec[i] = links[i+1].valid;
    assign eq_vec[i]  = links[i+1].eq;
  end

  // Handshake and broadcast
  assign in_stall   = out_valid_r && out_stall;
  assign accept     = in_valid && !in_stall;
  assign full       = (fill_r == CNT_W'(CAPACITY));
  assign found      = |eq_vec;
  assign op.operand = in_operand;
  assign op.ins_go  = accept && (in_action == ACT_INSERT) && !full;
  assign op.del_go  = accept && (in_action == ACT_DELETE) && found;

  // Form the next count and result beat
  always_comb begin
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    result_nxt    = result_r;
    smallest_nxt  = smallest_r;
    if (op.ins_go) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (op.del_go) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      smallest_nxt  = cell_valid_nxt[0] ? cell_value_nxt[0] : '0;
      if (op.ins_go || op.del_go) begin
        status_nxt = ST_DONE;
        result_nxt = in_operand;
      end else if (in_action == ACT_INSERT) begin
        status_nxt = ST_FULL;
        result_nxt = '0;
      end else begin
        status_nxt = ST_NOT_FOUND;
        result_nxt = '0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    result_r   <= result_nxt;
    smallest_r <= smallest_nxt;
    if (accept) begin
      count_r <= fill_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_result_value = result_r;
  assign out_entry_count  = count_r;
  assign out_smallest     = smallest_r;

  // The count never runs past the row length
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  // Occupied cells match the count
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(vld_vec) == int'(fill_r))
    else $error("cell valid bits disagree with fill count");

  // A refused insert leaves the list size alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_INSERT) && full |=> $stable(fill_r))
    else $error("refused insert changed the fill count");

  // A full status beat always reports a full list
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r == ST_FULL) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with list not full");

endmodule

@@ rtl/core/svl_cell.sv @@
// One storage cell of the sorted list: compares against the operand and shifts.
module svl_cell
  import svl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  svl_op_t                   op,
  input  svl_link_t                 left_in,
  input  svl_link_t                 right_in,
  output svl_link_t                 link_out,
  output logic                      valid_nxt,
  output logic signed [VALUE_W-1:0] value_nxt
);

  logic                      valid_r;
  logic signed [VALUE_W-1:0] value_r;
  logic                      lt;
  logic                      eq;

  // Compare the held entry with the operand
  assign lt = valid_r && ($signed(value_r) < $signed(op.operand));
  assign eq = valid_r && (value_r == op.operand);

  assign link_out.valid = valid_r;
  assign link_out.lt    = lt;
  assign link_out.eq    = eq;
  assign link_out.value = value_r;

  // Pick next contents: keep, take the operand, shift right or shift left
  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (op.ins_go && !lt) begin
      valid_nxt = valid_r | left_in.valid;
      if (left_in.lt) begin
        value_nxt = op.operand;
      end else begin
        value_nxt = left_in.value;
      end
    end else if (op.del_go && !lt) begin
      valid_nxt = right_in.valid;
      value_nxt = right_in.value;
    end
  end

  // Clear the valid bit under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the entry value
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
